[hdl/mipmo_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipmo_pkg
// Shared types, codes, sizes and the gamma table of the z-projection block.
// ----------------------------------------------------------------------------
package mipmo_pkg;

  localparam int unsigned MaxWidth  = 512;
  localparam int unsigned MaxHeight = 512;
  localparam int unsigned MaxDepth  = 1024;

  localparam int unsigned ColW   = $clog2(MaxWidth);
  localparam int unsigned RowW   = $clog2(MaxHeight);
  localparam int unsigned SliceW = $clog2(MaxDepth);
  localparam int unsigned AddrW  = RowW + ColW;

  // Register file: widths of the size registers follow the field widths.
  localparam int unsigned WidthRegW  = 10;
  localparam int unsigned HeightRegW = 10;
  localparam int unsigned DepthRegW  = 11;
  localparam int unsigned CfgDataW   = 11;
  localparam int unsigned CfgIdxW    = 2;

  localparam int unsigned OutColW = 10;
  localparam int unsigned OutRowW = 9;
  localparam int unsigned PixW    = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_DEPTH  = 2'd2,
    CFG_GAMMA  = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_READ = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_RANGE      = 2'd1,
    ERR_INCOMPLETE = 2'd2
  } rd_err_e;

  // One access toward the pixel store, issued at the accept edge.
  typedef struct packed {
    logic             valid;
    logic             is_read;
    logic             is_write;
    logic             first;
    logic             right;
    rd_err_e          err;
    logic [AddrW-1:0] addr;
    logic [PixW-1:0]  pix;
    logic [PixW-1:0]  mask;
  } req_t;

  typedef struct packed {
    logic [PixW-1:0] red;
    logic [PixW-1:0] green;
    logic [PixW-1:0] blue;
    rd_err_e         err;
  } res_t;

  typedef logic [PixW-1:0] gamma_rom_t [256];

  // Largest y with y^3 <= 255 * v^2, i.e. floor(255 * (v/255)^(2/3)).
  function automatic gamma_rom_t gamma_rom_f();
    gamma_rom_t  rom;
    int unsigned target;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    for (int v = 0; v < 256; v++) begin
      target = 255 * v * v;
      lo = 0;
      hi = 255;
      for (int k = 0; k < 10; k++) begin
        if (lo < hi) begin
          mid = (lo + hi + 1) / 2;
          if (mid * mid * mid <= target) begin
            lo = mid;
          end else begin
            hi = mid - 1;
          end
        end
      end
      rom[v] = lo[PixW-1:0];
    end
    return rom;
  endfunction

  localparam gamma_rom_t GammaRom = gamma_rom_f();

endpackage

[hdl/mipmo_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipmo_seq
// Raster position counters, frame status and request formation for the store.
// ----------------------------------------------------------------------------
module mipmo_seq (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               accept_i,
  input  logic                               command_i,
  input  logic                               frame_start_i,
  input  logic [mipmo_pkg::PixW-1:0]         voxel_value_i,
  input  logic [mipmo_pkg::PixW-1:0]         mask_value_i,
  input  logic [mipmo_pkg::OutColW-1:0]      out_col_i,
  input  logic [mipmo_pkg::OutRowW-1:0]      out_row_i,
  input  logic [mipmo_pkg::WidthRegW-1:0]    width_i,
  input  logic [mipmo_pkg::HeightRegW-1:0]   height_i,
  input  logic [mipmo_pkg::DepthRegW-1:0]    depth_i,
  input  logic                               gamma_en_i,
  output mipmo_pkg::req_t                    req_o
);

  logic [mipmo_pkg::ColW-1:0]   col_q, col_d, col_eff;
  logic [mipmo_pkg::RowW-1:0]   row_q, row_d, row_eff;
  logic [mipmo_pkg::SliceW-1:0] slice_q, slice_d, slice_eff;
  logic                         done_q, done_d, done_eff;

  logic                                load;
  logic [mipmo_pkg::ColW:0]            col_nx;
  logic [mipmo_pkg::RowW:0]            row_nx;
  logic [mipmo_pkg::SliceW:0]          slice_nx;
  logic                                col_wrap, row_wrap, slice_wrap;
  logic                                range_bad;
  logic                                right;
  logic [mipmo_pkg::OutColW-1:0]       src_col;
  logic [mipmo_pkg::PixW-1:0]          pix;

  assign load = accept_i && (mipmo_pkg::cmd_e'(command_i) == mipmo_pkg::CMD_LOAD);

  // A frame start takes effect before the voxel it comes with is placed.
  assign col_eff   = frame_start_i ? '0 : col_q;
  assign row_eff   = frame_start_i ? '0 : row_q;
  assign slice_eff = frame_start_i ? '0 : slice_q;
  assign done_eff  = frame_start_i ? 1'b0 : done_q;

  assign col_nx     = {1'b0, col_eff} + 1'b1;
  assign row_nx     = {1'b0, row_eff} + 1'b1;
  assign slice_nx   = {1'b0, slice_eff} + 1'b1;
  assign col_wrap   = col_nx >= width_i;
  assign row_wrap   = row_nx >= height_i;
  assign slice_wrap = slice_nx >= depth_i;

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    slice_d = slice_q;
    done_d  = done_q;
    if (load) begin
      col_d   = col_eff;
      row_d   = row_eff;
      slice_d = slice_eff;
      done_d  = done_eff;
      if (!done_eff) begin
        if (col_wrap) begin
          col_d = '0;
          if (row_wrap) begin
            row_d = '0;
            if (slice_wrap) begin
              slice_d = '0;
              done_d  = 1'b1;
            end else begin
              slice_d = slice_nx[mipmo_pkg::SliceW-1:0];
            end
          end else begin
            row_d = row_nx[mipmo_pkg::RowW-1:0];
          end
        end else begin
          col_d = col_nx[mipmo_pkg::ColW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      slice_q <= '0;
      done_q  <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      slice_q <= slice_d;
      done_q  <= done_d;
    end
  end

  assign range_bad = ({1'b0, out_col_i} >= {width_i, 1'b0}) ||
                     ({1'b0, out_row_i} >= height_i);
  assign right     = out_col_i >= width_i;
  assign src_col   = right ? (out_col_i - width_i) : out_col_i;
  assign pix       = gamma_en_i ? mipmo_pkg::GammaRom[voxel_value_i] : voxel_value_i;

  always_comb begin
    req_o          = '0;
    req_o.valid    = accept_i;
    req_o.is_read  = accept_i && !load;
    req_o.is_write = load && !done_eff;
    req_o.first    = slice_eff == '0;
    req_o.right    = right;
    req_o.pix      = pix;
    req_o.mask     = mask_value_i;
    if (load) begin
      req_o.addr = {row_eff, col_eff};
    end else begin
      req_o.addr = {out_row_i, src_col[mipmo_pkg::ColW-1:0]};
    end
    priority if (!done_q) begin
      req_o.err = mipmo_pkg::ERR_INCOMPLETE;
    end else if (range_bad) begin
      req_o.err = mipmo_pkg::ERR_RANGE;
    end else begin
      req_o.err = mipmo_pkg::ERR_NONE;
    end
  end

endmodule

[hdl/mipmo_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipmo_store
// Pixel store of image and label maxima with read-modify-write and bypass.
// ----------------------------------------------------------------------------
module mipmo_store (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mipmo_pkg::req_t req_i,
  output logic            pend_o,
  output logic            push_o,
  output mipmo_pkg::res_t res_o
);

  localparam int unsigned Depth = 1 << mipmo_pkg::AddrW;
  localparam int unsigned EntW  = 2 * mipmo_pkg::PixW;

  logic [EntW-1:0] mem [Depth];
  logic [EntW-1:0] rdata_q;

  logic            b_valid_q;
  mipmo_pkg::req_t b_q;

  logic                          byp_valid_q;
  logic [mipmo_pkg::AddrW-1:0]   byp_addr_q;
  logic [EntW-1:0]               byp_data_q;

  logic [EntW-1:0]               old;
  logic [mipmo_pkg::PixW-1:0]    old_img, old_lab, new_img, new_lab;
  logic                          we;

  // Image maximum in the low byte, label maximum in the high byte.
  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      rdata_q <= mem[req_i.addr];
    end
    if (we) begin
      mem[b_q.addr] <= {new_lab, new_img};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      byp_valid_q <= 1'b0;
    end else begin
      b_valid_q   <= req_i.valid;
      byp_valid_q <= we;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q        <= req_i;
    byp_addr_q <= b_q.addr;
    byp_data_q <= {new_lab, new_img};
  end

  // The write of the previous cycle is not yet in the word just read.
  assign old     = (byp_valid_q && (byp_addr_q == b_q.addr)) ? byp_data_q : rdata_q;
  assign old_img = old[mipmo_pkg::PixW-1:0];
  assign old_lab = old[EntW-1:mipmo_pkg::PixW];

  assign we      = b_valid_q && b_q.is_write;
  assign new_img = (b_q.first || (b_q.pix > old_img)) ? b_q.pix : old_img;
  assign new_lab = (b_q.first || (b_q.mask > old_lab)) ? b_q.mask : old_lab;

  assign pend_o = b_valid_q && b_q.is_read;
  assign push_o = pend_o;

  always_comb begin
    res_o     = '0;
    res_o.err = b_q.err;
    if (b_q.err == mipmo_pkg::ERR_NONE) begin
      if (b_q.right && (old_lab == '1)) begin
        res_o.green = '1;
      end else begin
        res_o.red   = old_img;
        res_o.green = old_img;
        res_o.blue  = old_img;
      end
    end
  end

endmodule

[hdl/mipmo_outq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mipmo_outq
// Small result queue that decouples the store from the output receiver.
// ----------------------------------------------------------------------------
module mipmo_outq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mipmo_pkg::res_t data_i,
  input  logic            pop_i,
  output logic            valid_o,
  output mipmo_pkg::res_t data_o,
  output logic [2:0]      count_o
);

  mipmo_pkg::res_t ent_q [4];
  logic [1:0]      wr_q, rd_q;
  logic [2:0]      cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + {2'b0, push_i} - {2'b0, pop_i};
    end
  end

  assign valid_o = cnt_q != '0;
  assign data_o  = ent_q[rd_q];
  assign count_o = cnt_q;

endmodule

[hdl/mip_with_mask_overlay_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mip_with_mask_overlay_top
// Z-axis maximum intensity projection with a green label overlay.
// ----------------------------------------------------------------------------
// Usage: voxels and read requests share the slave stream. tuser selects the
// word kind (0 load one voxel, 1 read one output pixel). A load word carries
// the voxel and its label value; loads go in slice-major raster order and a
// set frame start bit restarts the frame at voxel zero. Loads after a full
// frame are dropped until the next frame start. A read word names a pixel of
// the side-by-side result (grey left half, overlay right half); its RGB pixel
// leaves on the master stream with the read status in tuser.
// Throughput: one word per cycle, loads and reads alike, while the slave side
// is ready. Each word does one read of the pixel store, a memory with a single
// read port, and each load before the frame is full does one write-back;
// back-to-back hits on one pixel are forwarded. A read result passes the
// store's read register and then an entry of the result queue before it is
// offered on the master stream. A four-word result queue absorbs receiver
// stalls; the slave side stops only when that queue could overflow. Reset
// clears the counters and sets the sizes to 512 x 512 x 1024 with gamma on.
// The store itself is not cleared; it has no clearing pass. The user must
// write sizes on the configuration port while idle, not enforced by the block.
// ----------------------------------------------------------------------------
module mip_with_mask_overlay_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mipmo_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [mipmo_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [0] frame_start, [8:1] voxel_value, [16:9] mask_value, [26:17] out_col,
  // [35:27] out_row, [39:36] zero
  input  logic [39:0]                       s_axis_tdata,
  // [0] command
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [7:0] red, [15:8] green, [23:16] blue
  output logic [23:0]                       m_axis_tdata,
  // [1:0] read_error
  output logic [1:0]                        m_axis_tuser
);

  logic [mipmo_pkg::WidthRegW-1:0]  width_q, width_eff;
  logic [mipmo_pkg::HeightRegW-1:0] height_q, height_eff;
  logic [mipmo_pkg::DepthRegW-1:0]  depth_q, depth_eff;
  logic                             gamma_q;

  logic            accept;
  mipmo_pkg::req_t req;
  logic            pend;
  logic            push;
  mipmo_pkg::res_t res, q_data;
  logic [2:0]      q_count;
  logic            pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= mipmo_pkg::WidthRegW'(mipmo_pkg::MaxWidth);
      height_q <= mipmo_pkg::HeightRegW'(mipmo_pkg::MaxHeight);
      depth_q  <= mipmo_pkg::DepthRegW'(mipmo_pkg::MaxDepth);
      gamma_q  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (mipmo_pkg::cfg_idx_e'(cfg_idx_i))
        mipmo_pkg::CFG_WIDTH:  width_q  <= cfg_data_i[mipmo_pkg::WidthRegW-1:0];
        mipmo_pkg::CFG_HEIGHT: height_q <= cfg_data_i[mipmo_pkg::HeightRegW-1:0];
        mipmo_pkg::CFG_DEPTH:  depth_q  <= cfg_data_i[mipmo_pkg::DepthRegW-1:0];
        mipmo_pkg::CFG_GAMMA:  gamma_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Sizes outside the supported range are clamped to it.
  always_comb begin
    width_eff = width_q;
    if (width_q == '0) begin
      width_eff = mipmo_pkg::WidthRegW'(1);
    end else if (width_q > mipmo_pkg::WidthRegW'(mipmo_pkg::MaxWidth)) begin
      width_eff = mipmo_pkg::WidthRegW'(mipmo_pkg::MaxWidth);
    end
    height_eff = height_q;
    if (height_q == '0) begin
      height_eff = mipmo_pkg::HeightRegW'(1);
    end else if (height_q > mipmo_pkg::HeightRegW'(mipmo_pkg::MaxHeight)) begin
      height_eff = mipmo_pkg::HeightRegW'(mipmo_pkg::MaxHeight);
    end
    depth_eff = depth_q;
    if (depth_q == '0) begin
      depth_eff = mipmo_pkg::DepthRegW'(1);
    end else if (depth_q > mipmo_pkg::DepthRegW'(mipmo_pkg::MaxDepth)) begin
      depth_eff = mipmo_pkg::DepthRegW'(mipmo_pkg::MaxDepth);
    end
  end

  // Accept only while the queue can hold every result still in flight.
  assign s_axis_tready = (q_count + {2'b0, pend}) < 3'd4;
  assign accept        = s_axis_tvalid && s_axis_tready;

  mipmo_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .command_i     (s_axis_tuser),
    .frame_start_i (s_axis_tdata[0]),
    .voxel_value_i (s_axis_tdata[8:1]),
    .mask_value_i  (s_axis_tdata[16:9]),
    .out_col_i     (s_axis_tdata[26:17]),
    .out_row_i     (s_axis_tdata[35:27]),
    .width_i       (width_eff),
    .height_i      (height_eff),
    .depth_i       (depth_eff),
    .gamma_en_i    (gamma_q),
    .req_o         (req)
  );

  mipmo_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .pend_o (pend),
    .push_o (push),
    .res_o  (res)
  );

  assign pop = m_axis_tvalid && m_axis_tready;

  mipmo_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (res),
    .pop_i   (pop),
    .valid_o (m_axis_tvalid),
    .data_o  (q_data),
    .count_o (q_count)
  );

  assign m_axis_tdata = {q_data.blue, q_data.green, q_data.red};
  assign m_axis_tuser = q_data.err;

endmodule
